// ===== rtl/lpac_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpac_pkg: shared types and constants
// Widths, register indexes, CORDIC constants and the stage payload structs.
// ----------------------------------------------------------------------------
package lpac_pkg;

  localparam int COORD_BITS   = 16;
  localparam int FRAC_BITS    = 4;
  localparam int CORDIC_STEPS = 16;
  localparam int GUARD        = 8;
  localparam int CW           = COORD_BITS + GUARD + 3;  // CORDIC x/y width
  localparam int ZW           = 28;                      // angle accumulator width
  localparam int INV_GAIN     = 39797;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_TILT   = 3'd0,
    REG_MAX_CANGLE = 3'd1,
    REG_MAX_ASPECT = 3'd2,
    REG_MIN_AREA   = 3'd3,
    REG_MAX_GRAY   = 3'd4
  } reg_idx_t;

  function automatic logic signed [ZW-1:0] atan_entry(input int i);
    logic signed [ZW-1:0] v;
    unique case (i)
      0: v = 28'sd47185920;  1: v = 28'sd27855475;  2: v = 28'sd14718068;
      3: v = 28'sd7471121;   4: v = 28'sd3750058;   5: v = 28'sd1876857;
      6: v = 28'sd938658;    7: v = 28'sd469357;    8: v = 28'sd234682;
      9: v = 28'sd117342;    10: v = 28'sd58671;    11: v = 28'sd29335;
      12: v = 28'sd14668;    13: v = 28'sd7334;     14: v = 28'sd3667;
      15: v = 28'sd1833;     16: v = 28'sd917;      17: v = 28'sd458;
      18: v = 28'sd229;      19: v = 28'sd115;      20: v = 28'sd57;
      21: v = 28'sd29;       22: v = 28'sd14;       23: v = 28'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Side information that rides alongside the CORDIC pipeline.
  typedef struct packed {
    logic                  coincide;
    logic                  first_is_left;
    logic [COORD_BITS-1:0] mid_x;
    logic [COORD_BITS-1:0] mid_y;
    logic [COORD_BITS-1:0] short_max;
    logic [COORD_BITS-1:0] long_max;
    logic [COORD_BITS-1:0] long_min;
    logic                  tilt_ok;
    logic                  gray_ok;
  } side_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cordic_t;

endpackage

// ===== rtl/lpac_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpac_front: input stage
// Computes deltas, midpoint, edge extremes, tilt and gray checks.
// ----------------------------------------------------------------------------
module lpac_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [lpac_pkg::COORD_BITS-1:0] x1,
  input  logic [lpac_pkg::COORD_BITS-1:0] y1,
  input  logic [lpac_pkg::COORD_BITS-1:0] w1,
  input  logic [lpac_pkg::COORD_BITS-1:0] h1,
  input  logic signed [11:0]             a1,
  input  logic [lpac_pkg::COORD_BITS-1:0] x2,
  input  logic [lpac_pkg::COORD_BITS-1:0] y2,
  input  logic [lpac_pkg::COORD_BITS-1:0] w2,
  input  logic [lpac_pkg::COORD_BITS-1:0] h2,
  input  logic signed [11:0]             a2,
  input  logic [7:0]                     pix,
  input  logic [11:0]                    max_tilt,
  input  logic [8:0]                     max_gray,
  output logic                           out_valid,
  output lpac_pkg::cordic_t              out_c,
  output lpac_pkg::side_t                out_s
);
  import lpac_pkg::*;

  logic [COORD_BITS-1:0] adx, ady, mn1, mx1, mn2, mx2;
  // Tilts span -2047..3487, so their difference needs 14 signed bits.
  logic signed [13:0] t1, t2, td;
  logic [12:0] tabs;
  logic [COORD_BITS:0] sx, sy;
  cordic_t c_next;
  side_t s_next;

  always_comb begin
    adx = (x1 > x2) ? x1 - x2 : x2 - x1;
    ady = (y1 > y2) ? y1 - y2 : y2 - y1;
    mn1 = (w1 < h1) ? w1 : h1;  mx1 = (w1 < h1) ? h1 : w1;
    mn2 = (w2 < h2) ? w2 : h2;  mx2 = (w2 < h2) ? h2 : w2;
    t1 = (w1 < h1) ? -14'(a1) : 14'(a1) + 14'sd1440;
    t2 = (w2 < h2) ? -14'(a2) : 14'(a2) + 14'sd1440;
    td = t1 - t2;
    tabs = td[13] ? 13'(-td) : 13'(td);
    sx = {1'b0, x1} + {1'b0, x2};
    sy = {1'b0, y1} + {1'b0, y2};
    c_next.x = CW'({adx, {GUARD{1'b0}}});
    c_next.y = CW'({ady, {GUARD{1'b0}}});
    c_next.z = '0;
    s_next.coincide      = (adx == '0) && (ady == '0);
    s_next.first_is_left = x1 < x2;
    s_next.mid_x         = sx[COORD_BITS:1];
    s_next.mid_y         = sy[COORD_BITS:1];
    s_next.short_max     = (mn1 > mn2) ? mn1 : mn2;
    s_next.long_max      = (mx1 > mx2) ? mx1 : mx2;
    s_next.long_min      = (mx1 < mx2) ? mx1 : mx2;
    s_next.tilt_ok       = tabs < {1'b0, max_tilt};
    s_next.gray_ok       = {1'b0, pix} < max_gray;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_c <= c_next;
      out_s <= s_next;
    end
  end

endmodule

// ===== rtl/lpac_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpac_cordic: vectoring CORDIC pipeline
// One registered micro-rotation per stage, side data carried along.
// ----------------------------------------------------------------------------
module lpac_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  lpac_pkg::cordic_t in_c,
  input  lpac_pkg::side_t   in_s,
  output logic              out_valid,
  output lpac_pkg::cordic_t out_c,
  output lpac_pkg::side_t   out_s
);
  import lpac_pkg::*;

  logic    vld [CORDIC_STEPS+1];
  cordic_t cs  [CORDIC_STEPS+1];
  side_t   ss  [CORDIC_STEPS+1];

  assign vld[0] = in_valid;
  assign cs[0]  = in_c;
  assign ss[0]  = in_s;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    cordic_t nxt;
    logic signed [CW-1:0] shx, shy;
    always_comb begin
      shx = cs[i].x >>> i;
      shy = cs[i].y >>> i;
      if (!cs[i].y[CW-1]) begin
        nxt.x = cs[i].x + shy;
        nxt.y = cs[i].y - shx;
        nxt.z = cs[i].z + atan_entry(i);
      end else begin
        nxt.x = cs[i].x - shy;
        nxt.y = cs[i].y + shx;
        nxt.z = cs[i].z - atan_entry(i);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        cs[i+1] <= nxt;
        ss[i+1] <= ss[i];
      end
    end
  end

  assign out_valid = vld[CORDIC_STEPS];
  assign out_c     = cs[CORDIC_STEPS];
  assign out_s     = ss[CORDIC_STEPS];

endmodule

// ===== rtl/lpac_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpac_back: scaling, sides and checks
// Three registered stages: gain multiply, sides, products and decision.
// ----------------------------------------------------------------------------
module lpac_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  lpac_pkg::cordic_t               in_c,
  input  lpac_pkg::side_t                 in_s,
  input  logic [10:0]                     max_cangle,
  input  logic [15:0]                     max_aspect,
  input  logic [23:0]                     min_area,
  output logic                            out_valid,
  output logic                            accepted,
  output logic                            first_is_left,
  output logic [lpac_pkg::COORD_BITS-1:0] center_x,
  output logic [lpac_pkg::COORD_BITS-1:0] center_y,
  output logic [lpac_pkg::COORD_BITS-1:0] long_side,
  output logic [lpac_pkg::COORD_BITS-1:0] short_side,
  output logic [10:0]                     angle
);
  import lpac_pkg::*;

  localparam int DW = CW + 17 - (16 + GUARD);  // distance width
  localparam int SW = (DW > COORD_BITS ? DW : COORD_BITS) + 1;

  // Stage A: gain multiply and angle rounding.
  logic            va;
  side_t           sa;
  logic [CW+16:0]  prod_a;
  logic [10:0]     ang_a;
  logic [CW-1:0]   xpos;
  logic signed [ZW-1:0] zr;
  logic [ZW-17:0]  zq;
  logic [10:0]     ang_next;

  always_comb begin
    xpos = in_c.x[CW-1] ? '0 : in_c.x;
    zr = in_c.z[ZW-1] ? '0 : in_c.z;
    zq = (ZW-16)'((zr + ZW'(32768)) >>> 16);
    ang_next = (zq > (ZW-16)'(1440)) ? 11'd1440 : 11'(zq);
    if (in_s.coincide) ang_next = '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa     <= in_s;
      prod_a <= (CW+17)'(xpos) * (CW+17)'(INV_GAIN);
      ang_a  <= ang_next;
    end
  end

  // Stage B: distance and sides.
  logic [DW-1:0] cdist;
  logic [SW-1:0] aw, ah, sl_next, ss_next;
  logic          vb;
  side_t         sb;
  logic [SW-1:0] sl_b, ss_b;
  logic [10:0]   ang_b;

  always_comb begin
    cdist = DW'((prod_a + ((CW+17)'(1) << (15 + GUARD))) >> (16 + GUARD));
    if (sa.coincide) cdist = '0;
    aw = (SW'(cdist) > SW'(sa.short_max)) ? SW'(cdist) - SW'(sa.short_max)
                                          : SW'(sa.short_max) - SW'(cdist);
    ah = SW'(sa.long_max);
    sl_next = (aw > ah) ? aw : ah;
    ss_next = (aw > ah) ? ah : aw;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb    <= sa;
      sl_b  <= sl_next;
      ss_b  <= ss_next;
      ang_b <= ang_a;
    end
  end

  // Stage C: products and final decision.
  logic [SW+SW-1:0] area;
  logic [SW+15:0]   lhs, rhs;
  logic             ok;

  always_comb begin
    area = (2*SW)'(sl_b) * (2*SW)'(ss_b);
    lhs  = (SW+16)'(sl_b) << 8;
    rhs  = (SW+16)'(max_aspect) * (SW+16)'(ss_b);
    ok = !sb.coincide && sb.tilt_ok && sb.gray_ok
         && ({1'b0, sb.long_max} < {sb.long_min, 1'b0})
         && (ang_b < max_cangle)
         && (lhs < rhs)
         && (area > ((2*SW)'(min_area) << (2*FRAC_BITS)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      accepted      <= ok;
      first_is_left <= sb.first_is_left;
      center_x      <= sb.mid_x;
      center_y      <= sb.mid_y;
      long_side     <= (sl_b > SW'({COORD_BITS{1'b1}})) ? '1 : COORD_BITS'(sl_b);
      short_side    <= (ss_b > SW'({COORD_BITS{1'b1}})) ? '1 : COORD_BITS'(ss_b);
      angle         <= ang_b;
    end
  end

  // An accepted pair never reports an angle at or above the limit.
  a_angle_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> angle < max_cangle) else $error("angle check");
  // An accepted pair has a nonzero short side.
  a_short_nz: assert property (@(posedge clk) disable iff (rst)
    out_valid && accepted |-> short_side != '0) else $error("short side");
  // Long side never below short side.
  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> long_side >= short_side) else $error("side order");

endmodule

// ===== rtl/light_pair_armor_check_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_pair_armor_check_top: armor plate check for a pair of lights
// Fully pipelined front stage, CORDIC rotations and three back stages.
// ----------------------------------------------------------------------------
// Path: the front register, the CORDIC_STEPS rotation registers and the three
// back-stage registers lie between input transfer and result.
// Throughput: one pair per cycle; every stage is a register stage that holds
// under back-pressure, so a stall freezes the whole pipe.
// Reset: rst, synchronous, clears all valid bits and loads the configuration
// registers with their default values.
module light_pair_armor_check_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [lpac_pkg::COORD_BITS-1:0] first_center_x,
  input  logic [lpac_pkg::COORD_BITS-1:0] first_center_y,
  input  logic [lpac_pkg::COORD_BITS-1:0] first_width,
  input  logic [lpac_pkg::COORD_BITS-1:0] first_height,
  input  logic signed [11:0]              first_angle,
  input  logic [lpac_pkg::COORD_BITS-1:0] second_center_x,
  input  logic [lpac_pkg::COORD_BITS-1:0] second_center_y,
  input  logic [lpac_pkg::COORD_BITS-1:0] second_width,
  input  logic [lpac_pkg::COORD_BITS-1:0] second_height,
  input  logic signed [11:0]              second_angle,
  input  logic [7:0]                      mid_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            accepted,
  output logic                            first_is_left,
  output logic [lpac_pkg::COORD_BITS-1:0] armor_center_x,
  output logic [lpac_pkg::COORD_BITS-1:0] armor_center_y,
  output logic [lpac_pkg::COORD_BITS-1:0] armor_long_side,
  output logic [lpac_pkg::COORD_BITS-1:0] armor_short_side,
  output logic [10:0]                     armor_angle,
  input  logic                            cfg_we,
  input  logic [lpac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lpac_pkg::*;

  // Configuration registers.
  logic [11:0] max_tilt_difference;
  logic [10:0] max_center_angle;
  logic [15:0] max_aspect_ratio;
  logic [23:0] min_armor_area;
  logic [8:0]  max_mid_gray;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_tilt_difference <= 12'd160;
      max_center_angle    <= 11'd320;
      max_aspect_ratio    <= 16'd1024;
      min_armor_area      <= 24'd100;
      max_mid_gray        <= 9'd128;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_TILT:   max_tilt_difference <= cfg_data[11:0];
        REG_MAX_CANGLE: max_center_angle    <= cfg_data[10:0];
        REG_MAX_ASPECT: max_aspect_ratio    <= cfg_data[15:0];
        REG_MIN_AREA:   min_armor_area      <= cfg_data[23:0];
        REG_MAX_GRAY:   max_mid_gray        <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  // The pipe advances whenever the output slot is empty or being drained.
  // This is a single global enable, so the input ready follows out_ready
  // combinationally while a result is waiting.
  logic en;
  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  logic    f_valid, c_valid;
  cordic_t f_c, c_c;
  side_t   f_s, c_s;

  lpac_front u_front (
    .clk, .rst, .en, .in_valid,
    .x1(first_center_x), .y1(first_center_y), .w1(first_width),
    .h1(first_height), .a1(first_angle),
    .x2(second_center_x), .y2(second_center_y), .w2(second_width),
    .h2(second_height), .a2(second_angle),
    .pix(mid_pixel), .max_tilt(max_tilt_difference), .max_gray(max_mid_gray),
    .out_valid(f_valid), .out_c(f_c), .out_s(f_s)
  );

  lpac_cordic u_cordic (
    .clk, .rst, .en, .in_valid(f_valid), .in_c(f_c), .in_s(f_s),
    .out_valid(c_valid), .out_c(c_c), .out_s(c_s)
  );

  lpac_back u_back (
    .clk, .rst, .en, .in_valid(c_valid), .in_c(c_c), .in_s(c_s),
    .max_cangle(max_center_angle), .max_aspect(max_aspect_ratio),
    .min_area(min_armor_area),
    .out_valid, .accepted, .first_is_left,
    .center_x(armor_center_x), .center_y(armor_center_y),
    .long_side(armor_long_side), .short_side(armor_short_side),
    .angle(armor_angle)
  );

endmodule
